// File: rtl/wpm_pkg.sv
`timescale 1ns / 1ps
// Shared constants, opcode values and controller/datapath interface types.
package wpm_pkg;

	localparam int SAMPLE_W = 32;
	localparam int VAL_W    = 31;
	localparam int SEEN_W   = 64;

	localparam logic [1:0] OP_RECORD = 2'd0;
	localparam logic [1:0] OP_SNAP   = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	localparam int PCT_LO  = 95;
	localparam int PCT_HI  = 99;
	localparam int PCT_DEN = 100;

	typedef struct packed {
		logic     rec;
		logic     clr;
		logic     nop;
		logic     snap_empty;
		logic     snap_init;
		logic     div_start;
		logic     scan_start;
		logic     scan_issue;
		logic     eval;
		logic     next_cand;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic div_done;
		logic scan_last;
		logic cand_last;
	} sts_t;

endpackage

// File: rtl/window_percentile_monitor_top.sv
`timescale 1ns / 1ps
// Sliding-window percentile monitor: record, snapshot and clear words.
// Record, clear, unused, empty snapshot: result in the cycle after accept, busy stays low.
// Snapshot of n samples: n candidate passes over the dual-read-port sample RAM, each a scan,
// a read drain and a rank compare, then a mean divide of the (31 + counter width)-bit sum.
// Busy is high until the result is given. No result stalls.
// arst_n clears the counters and controller; the sample RAM is not cleared.
module window_percentile_monitor_top #(
	parameter int WINDOW_DEPTH = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          op,
	input  logic signed [wpm_pkg::SAMPLE_W-1:0] sample,
	output logic                                result_valid,
	output logic                                accepted,
	output logic                                available,
	output logic [wpm_pkg::SEEN_W-1:0]          observed_frames,
	output logic [$clog2(WINDOW_DEPTH+1)-1:0]   window_samples,
	output logic [wpm_pkg::VAL_W-1:0]           mean_value,
	output logic [wpm_pkg::VAL_W-1:0]           p95_value,
	output logic [wpm_pkg::VAL_W-1:0]           p99_value
);
	import wpm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	wpm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	wpm_dp #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.sample          (sample),
		.result_valid    (result_valid),
		.accepted        (accepted),
		.available       (available),
		.observed_frames (observed_frames),
		.window_samples  (window_samples),
		.mean_value      (mean_value),
		.p95_value       (p95_value),
		.p99_value       (p99_value)
	);

endmodule

// File: rtl/wpm_ram.sv
`timescale 1ns / 1ps
// Generic RAM: one write port, two registered read ports.
module wpm_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a,
	output logic [WIDTH-1:0]                       rdata_a,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b,
	output logic [WIDTH-1:0]                       rdata_b
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// File: rtl/wpm_div.sv
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
module wpm_div #(
	parameter int NW = 40,
	parameter int DW = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] num_q;
	logic [DW-1:0] den_q;
	logic [DW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [DW:0]   rem_sh;
	logic          ge;
	logic [DW:0]   rem_n;

	assign rem_sh = {rem_q, num_q[NW-1]};
	assign ge     = rem_sh >= {1'b0, den_q};
	assign rem_n  = ge ? rem_sh - {1'b0, den_q} : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= rem_n[DW-1:0];
			num_q <= {num_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = num_q;

endmodule

// File: rtl/wpm_dp.sv
`timescale 1ns / 1ps
// Datapath: sample ring, counters, rank selection scan, divider and result word.
module wpm_dp #(
	parameter int WINDOW_DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  wpm_pkg::cmd_t                         cmd,
	output wpm_pkg::sts_t                         sts,
	input  logic signed [wpm_pkg::SAMPLE_W-1:0]   sample,
	output logic                                  result_valid,
	output logic                                  accepted,
	output logic                                  available,
	output logic [wpm_pkg::SEEN_W-1:0]            observed_frames,
	output logic [$clog2(WINDOW_DEPTH+1)-1:0]     window_samples,
	output logic [wpm_pkg::VAL_W-1:0]             mean_value,
	output logic [wpm_pkg::VAL_W-1:0]             p95_value,
	output logic [wpm_pkg::VAL_W-1:0]             p99_value
);
	import wpm_pkg::*;

	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int AW    = WINDOW_DEPTH > 1 ? $clog2(WINDOW_DEPTH) : 1;
	localparam int PW    = CNT_W + 7;
	localparam int SUM_W = VAL_W + CNT_W;

	logic [AW-1:0]     wr_q;
	logic [CNT_W-1:0]  fill_q;
	logic [SEEN_W-1:0] seen_q;
	logic [CNT_W-1:0]  i_q;
	logic [CNT_W-1:0]  j_q;
	logic [CNT_W-1:0]  less_q;
	logic [CNT_W-1:0]  leq_q;
	logic [PW-1:0]     pn95_q;
	logic [PW-1:0]     pn99_q;
	logic [SUM_W-1:0]  sum_q;
	logic [VAL_W-1:0]  p95_q;
	logic [VAL_W-1:0]  p99_q;
	logic              rd_vld_s1;
	logic              out_v_q;

	logic              rec_ok;
	logic [CNT_W-1:0]  fill_n;
	logic [SEEN_W-1:0] seen_n;
	logic [VAL_W-1:0]  cand;
	logic [VAL_W-1:0]  scan_v;
	logic [PW-1:0]     less_x;
	logic [PW-1:0]     leq_x;
	logic              div_done;
	logic [SUM_W-1:0]  div_quo;

	assign rec_ok = cmd.rec && !sample[SAMPLE_W-1];
	assign fill_n = (fill_q < CNT_W'(WINDOW_DEPTH)) ? fill_q + 1'b1 : fill_q;
	assign seen_n = (&seen_q) ? seen_q : seen_q + 1'b1;

	wpm_ram #(.WIDTH(VAL_W), .DEPTH(WINDOW_DEPTH)) u_ram (
		.clk     (clk),
		.we      (rec_ok),
		.waddr   (wr_q),
		.wdata   (sample[VAL_W-1:0]),
		.raddr_a (i_q[AW-1:0]),
		.rdata_a (cand),
		.raddr_b (j_q[AW-1:0]),
		.rdata_b (scan_v)
	);

	wpm_div #(.NW(SUM_W), .DW(CNT_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (sum_q),
		.den    (fill_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign sts.empty     = (fill_q == '0);
	assign sts.div_done  = div_done;
	assign sts.scan_last = (j_q == fill_q - 1'b1);
	assign sts.cand_last = (i_q == fill_q - 1'b1);

	assign less_x = PW'(less_q) * PW'(PCT_DEN);
	assign leq_x  = PW'(leq_q) * PW'(PCT_DEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q      <= '0;
			fill_q    <= '0;
			seen_q    <= '0;
			rd_vld_s1 <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_issue;
			out_v_q   <= cmd.rec || cmd.clr || cmd.nop || cmd.snap_empty || div_done;
			if (rec_ok) begin
				wr_q   <= (wr_q == AW'(WINDOW_DEPTH - 1)) ? '0 : wr_q + 1'b1;
				fill_q <= fill_n;
				seen_q <= seen_n;
			end else if (cmd.clr) begin
				wr_q   <= '0;
				fill_q <= '0;
				seen_q <= '0;
			end
		end
	end

	// selection: rank r = ceil(P*n/100), candidate i holds it when
	// 100*less < P*n <= 100*less_or_equal
	always_ff @(posedge clk) begin
		if (cmd.snap_init) begin
			i_q    <= '0;
			sum_q  <= '0;
			pn95_q <= PW'(fill_q) * PW'(PCT_LO);
			pn99_q <= PW'(fill_q) * PW'(PCT_HI);
		end else if (cmd.next_cand) begin
			i_q <= i_q + 1'b1;
		end
		if (cmd.scan_start) begin
			j_q    <= '0;
			less_q <= '0;
			leq_q  <= '0;
		end else begin
			if (cmd.scan_issue) begin
				j_q <= j_q + 1'b1;
			end
			if (rd_vld_s1) begin
				if (scan_v < cand) begin
					less_q <= less_q + 1'b1;
				end
				if (scan_v <= cand) begin
					leq_q <= leq_q + 1'b1;
				end
				if (i_q == '0) begin
					sum_q <= sum_q + SUM_W'(scan_v);
				end
			end
		end
		if (cmd.eval) begin
			if (less_x < pn95_q && pn95_q <= leq_x) begin
				p95_q <= cand;
			end
			if (less_x < pn99_q && pn99_q <= leq_x) begin
				p99_q <= cand;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_done) begin
			accepted        <= 1'b0;
			available       <= 1'b1;
			observed_frames <= seen_q;
			window_samples  <= fill_q;
			mean_value      <= div_quo[VAL_W-1:0];
			p95_value       <= p95_q;
			p99_value       <= p99_q;
		end else if (cmd.rec) begin
			accepted        <= rec_ok;
			available       <= 1'b0;
			observed_frames <= rec_ok ? seen_n : seen_q;
			window_samples  <= rec_ok ? fill_n : fill_q;
			mean_value      <= '0;
			p95_value       <= '0;
			p99_value       <= '0;
		end else if (cmd.snap_empty) begin
			accepted        <= 1'b0;
			available       <= 1'b0;
			observed_frames <= seen_q;
			window_samples  <= fill_q;
			mean_value      <= '0;
			p95_value       <= '0;
			p99_value       <= '0;
		end else if (cmd.clr || cmd.nop) begin
			accepted        <= 1'b0;
			available       <= 1'b0;
			observed_frames <= '0;
			window_samples  <= '0;
			mean_value      <= '0;
			p95_value       <= '0;
			p99_value       <= '0;
		end
	end

	assign result_valid = out_v_q;

endmodule

// File: rtl/wpm_ctrl.sv
`timescale 1ns / 1ps
// Controller: decodes words and sequences the snapshot scan and mean divide.
module wpm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [1:0]    op,
	output logic          busy,
	output wpm_pkg::cmd_t cmd,
	input  wpm_pkg::sts_t sts
);
	import wpm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_EVAL,
		S_MEAN
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (op)
						OP_RECORD: cmd.rec = 1'b1;
						OP_CLEAR:  cmd.clr = 1'b1;
						OP_SNAP: begin
							if (sts.empty) begin
								cmd.snap_empty = 1'b1;
							end else begin
								cmd.snap_init  = 1'b1;
								cmd.scan_start = 1'b1;
								state_d        = S_SCAN;
							end
						end
						default:   cmd.nop = 1'b1;
					endcase
				end
			end
			S_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (sts.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: state_d = S_EVAL;
			S_EVAL: begin
				cmd.eval = 1'b1;
				if (sts.cand_last) begin
					cmd.div_start = 1'b1;
					state_d       = S_MEAN;
				end else begin
					cmd.next_cand  = 1'b1;
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_MEAN: begin
				if (sts.div_done) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE);
		end
	end

	assign busy = busy_q;

endmodule

// File: rtl/wpm_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the percentile monitor, bound to the top level.
module wpm_checker #(
	parameter int WINDOW_DEPTH = 256
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic [1:0]                        op,
	input logic                              result_valid,
	input logic                              accepted,
	input logic                              available,
	input logic [wpm_pkg::SEEN_W-1:0]        observed_frames,
	input logic [$clog2(WINDOW_DEPTH+1)-1:0] window_samples,
	input logic [wpm_pkg::VAL_W-1:0]         p95_value,
	input logic [wpm_pkg::VAL_W-1:0]         p99_value
);
	import wpm_pkg::*;

	a_quick_word: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && op != OP_SNAP |=> result_valid)
		else $error("non-snapshot word gave no result next cycle");

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && op == OP_CLEAR |=> observed_frames == '0 && window_samples == '0)
		else $error("clear left counters nonzero");

	a_snap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && op == OP_SNAP |=> busy || result_valid)
		else $error("snapshot neither busy nor answered");

	a_rank_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && available |-> window_samples != '0 && p95_value <= p99_value)
		else $error("snapshot percentiles out of order");

	a_rec_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && accepted |-> observed_frames != '0 && window_samples != '0)
		else $error("stored sample not counted");

endmodule

bind window_percentile_monitor_top wpm_checker #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_wpm_checker (.*);

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sliding-window percentile monitor.
module testbench;
	import wpm_pkg::*;

	localparam int DEPTH     = 256;
	localparam int WS_W      = $clog2(DEPTH + 1);
	localparam int CYC_LIMIT = 60000000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic              accepted;
		logic              available;
		logic [SEEN_W-1:0] observed;
		logic [WS_W-1:0]   fill;
		logic [VAL_W-1:0]  mean;
		logic [VAL_W-1:0]  p95;
		logic [VAL_W-1:0]  p99;
	} stats_t;

	typedef struct {
		logic [1:0]           op;
		logic [SAMPLE_W-1:0]  sample;
		bit                   typed;
		stats_t               want;
	} row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [1:0]          op = OP_RECORD;
	logic [SAMPLE_W-1:0] sample = '0;
	logic                busy, result_valid, accepted, available;
	logic [SEEN_W-1:0]   observed_frames;
	logic [WS_W-1:0]     window_samples;
	logic [VAL_W-1:0]    mean_value, p95_value, p99_value;

	// predictor state
	logic [VAL_W-1:0]  ring [DEPTH];
	int unsigned       wr_idx, fill_cnt;
	logic [SEEN_W-1:0] seen_cnt;

	stats_t pending_stats [$];
	int     mismatches, words_sent, snaps_sent, full_snaps, cycles;
	bit     quiet;

	window_percentile_monitor_top #(.WINDOW_DEPTH(DEPTH)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.sample(sample), .result_valid(result_valid), .accepted(accepted),
		.available(available), .observed_frames(observed_frames),
		.window_samples(window_samples), .mean_value(mean_value),
		.p95_value(p95_value), .p99_value(p99_value)
	);

	always #2 clk = ~clk;

	function automatic stats_t predict_stats(logic [1:0] o, logic [SAMPLE_W-1:0] s);
		stats_t r;
		logic [VAL_W-1:0] srt [DEPTH];
		logic [VAL_W-1:0] v;
		logic [63:0] sum;
		int unsigned n, j, rk;
		r = '0;
		case (o)
			OP_RECORD: begin
				if (!s[SAMPLE_W-1]) begin
					ring[wr_idx] = s[VAL_W-1:0];
					wr_idx = (wr_idx + 1) % DEPTH;
					if (fill_cnt < DEPTH) fill_cnt++;
					if (seen_cnt != '1) seen_cnt++;
					r.accepted = 1'b1;
				end
				r.observed = seen_cnt;
				r.fill = WS_W'(fill_cnt);
			end
			OP_SNAP: begin
				n = fill_cnt;
				r.observed = seen_cnt;
				r.fill = WS_W'(n);
				if (n > 0) begin
					sum = '0;
					for (int i = 0; i < n; i++) begin
						v = ring[i];
						sum += v;
						j = i;
						while (j > 0 && srt[j-1] > v) begin
							srt[j] = srt[j-1];
							j--;
						end
						srt[j] = v;
					end
					r.available = 1'b1;
					r.mean = VAL_W'(sum / n);
					rk = (PCT_LO * n + 99) / PCT_DEN;
					rk = (rk < 1) ? 1 : (rk > n) ? n : rk;
					r.p95 = srt[rk-1];
					rk = (PCT_HI * n + 99) / PCT_DEN;
					rk = (rk < 1) ? 1 : (rk > n) ? n : rk;
					r.p99 = srt[rk-1];
				end
			end
			OP_CLEAR: begin
				wr_idx = 0;
				fill_cnt = 0;
				seen_cnt = '0;
			end
			default: ;
		endcase
		return r;
	endfunction

	// drive one word and hold it until taken; gap is idle cycles before it
	task automatic send_word(logic [1:0] o, logic [SAMPLE_W-1:0] s, int gap,
			bit typed, stats_t want);
		stats_t p;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		op <= o;
		sample <= s;
		do @(posedge clk); while (busy);
		p = predict_stats(o, s);
		pending_stats.push_back(typed ? want : p);
		words_sent++;
		if (o == OP_SNAP) begin
			snaps_sent++;
			if (fill_cnt == DEPTH) full_snaps++;
		end
	endtask

	function automatic int pick_gap();
		if (quiet || $urandom_range(0, 99) < 65) return 0;
		return $urandom_range(1, 15);
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0:       return $urandom | 32'h8000_0000;   // rejected
			1, 2:    return $urandom & 32'h7FFF_FFFF;
			3:       return {1'b0, {31{1'b1}}} - $urandom_range(0, 3);
			4:       return $urandom_range(0, 3);
			default: return $urandom_range(0, 32'h0064_0000);
		endcase
	endfunction

	task automatic run_window(int n);
		if ($urandom_range(0, 3) != 0) send_word(OP_CLEAR, $urandom, pick_gap(), 0, '0);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 19) == 0)
				send_word(OP_UNUSED, $urandom, pick_gap(), 0, '0);
			send_word(OP_RECORD, pick_sample(), pick_gap(), 0, '0);
		end
		send_word(OP_SNAP, $urandom, pick_gap(), 0, '0);
	endtask

	always @(posedge clk) begin
		stats_t got, want;
		if (result_valid) begin
			got = '{accepted, available, observed_frames, window_samples,
				mean_value, p95_value, p99_value};
			if (pending_stats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %p", got);
			end else begin
				want = pending_stats.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYC_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		row_t rows [$];
		int target;
		wr_idx = 0;
		fill_cnt = 0;
		seen_cnt = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty snapshot, field extremes, rejects, unused op, clear
		rows = '{
			'{OP_SNAP,   32'h0,         1, '0},
			'{OP_RECORD, 32'h0,         1, '{1'b1, 1'b0, 64'd1, 9'd1, 31'd0, 31'd0, 31'd0}},
			'{OP_RECORD, 32'h7FFF_FFFF, 1, '{1'b1, 1'b0, 64'd2, 9'd2, 31'd0, 31'd0, 31'd0}},
			'{OP_RECORD, 32'h8000_0000, 1, '{1'b0, 1'b0, 64'd2, 9'd2, 31'd0, 31'd0, 31'd0}},
			'{OP_RECORD, 32'hFFFF_FFFF, 1, '{1'b0, 1'b0, 64'd2, 9'd2, 31'd0, 31'd0, 31'd0}},
			'{OP_SNAP,   32'hFFFF_FFFF, 0, '0},
			'{OP_UNUSED, 32'h5555_5555, 1, '0},
			'{OP_RECORD, 32'h5555_5555, 0, '0},
			'{OP_RECORD, 32'h2AAA_AAAA, 0, '0},
			'{OP_SNAP,   32'h0,         0, '0},
			'{OP_CLEAR,  32'hFFFF_FFFF, 1, '0},
			'{OP_SNAP,   32'h0,         1, '0},
			'{OP_RECORD, 32'h0001_0000, 0, '0},
			'{OP_SNAP,   32'h0,         1, '{1'b0, 1'b1, 64'd1, 9'd1, 31'h10000, 31'h10000,
				31'h10000}},
			'{OP_RECORD, 32'h0000_0001, 0, '0},
			'{OP_RECORD, 32'h0001_0000, 0, '0},
			'{OP_RECORD, 32'h7FFF_FFFE, 0, '0},
			'{OP_SNAP,   32'h0,         0, '0},
			'{OP_CLEAR,  32'h0,         1, '0}
		};
		foreach (rows[i])
			send_word(rows[i].op, rows[i].sample, (i % 3 == 1) ? $urandom_range(1, 15) : 0,
				rows[i].typed, rows[i].want);

		// random: mostly small windows, a couple run past the ring size to wrap
		while (words_sent < 500) begin
			if (words_sent > 420) quiet = 1;
			case ($urandom_range(0, 19))
				0:       target = (full_snaps < 2 && words_sent < 300) ?
					DEPTH + $urandom_range(1, 40) : 8;
				1, 2:    target = $urandom_range(20, 48);
				default: target = $urandom_range(1, 12);
			endcase
			run_window(target);
		end
		start <= 1'b0;

		while (pending_stats.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("%0d words sent, %0d snapshots (%0d of a full ring), %0d mismatches",
			words_sent, snaps_sent, full_snaps, mismatches);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

// File: files.f
rtl/wpm_pkg.sv
rtl/wpm_ram.sv
rtl/wpm_div.sv
rtl/wpm_dp.sv
rtl/wpm_ctrl.sv
rtl/window_percentile_monitor_top.sv
rtl/wpm_checker.sv
dv/testbench.sv
